@@ rtl/lfu_pkg.sv @@
`timescale 1ns / 1ps

package lfu_pkg;

  localparam int KEY_BITS           = 16;
  localparam int VALUE_BITS         = 32;
  localparam int CFG_BITS           = 5;
  localparam int CAPACITY_DEFAULT   = 16;
  localparam int COUNT_BITS_DEFAULT = 16;

  localparam logic [CFG_BITS-1:0] CAPACITY_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
  } res_t;

endpackage

@@ rtl/lfu_req_if.sv @@
`timescale 1ns / 1ps

interface lfu_req_if;
  import lfu_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] write_value;

  modport source (output valid, output opcode, output key, output write_value, input ready);
  modport sink (input valid, input opcode, input key, input write_value, output ready);
endinterface

@@ rtl/lfu_rsp_if.sv @@
`timescale 1ns / 1ps

interface lfu_rsp_if;
  import lfu_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink (input valid, input hit, input read_value, input evicted,
                input evicted_key, output ready);
endinterface

@@ rtl/lfu_mem.sv @@
`timescale 1ns / 1ps

module lfu_mem #(
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = 4,
  parameter int WORD_BITS = 68
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/lfu_engine.sv @@
`timescale 1ns / 1ps

module lfu_engine #(
  parameter int CAPACITY   = lfu_pkg::CAPACITY_DEFAULT,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lfu_pkg::CFG_BITS-1:0]  cap,
  input  logic                          req_valid,
  input  lfu_pkg::req_t                 req,
  output logic                          req_ready,
  output logic                          res_valid,
  output lfu_pkg::res_t                 res,
  input  logic                          res_take
);
  import lfu_pkg::*;

  localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int CMP_BITS  = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
  localparam int WORD_BITS = KEY_BITS + VALUE_BITS + COUNT_BITS + IDX_BITS;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0] count;
    logic [IDX_BITS-1:0]   rank;
  } entry_t;

  typedef enum logic [2:0] {IDLE, SCAN, DECIDE, UPDATE, DONE} state_t;

  state_t                state;
  logic [CAPACITY-1:0]   valid;
  logic [CNT_BITS-1:0]   occupancy;
  logic [CNT_BITS-1:0]   cnt;
  logic                  rd_pend;
  logic [IDX_BITS-1:0]   rd_idx;

  logic                  op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] wval_r;

  logic                  match_found;
  logic [IDX_BITS-1:0]   match_idx;
  logic [IDX_BITS-1:0]   m_rank;
  logic [VALUE_BITS-1:0] m_value;
  logic                  vic_found;
  logic [IDX_BITS-1:0]   vic_idx;
  logic [COUNT_BITS-1:0] vic_count;
  logic [IDX_BITS-1:0]   vic_rank;
  logic [KEY_BITS-1:0]   vic_key;
  logic                  free_found;
  logic [IDX_BITS-1:0]   free_idx;

  logic                  upd_ins;
  logic                  evict_r;
  logic [IDX_BITS-1:0]   slot_idx;

  logic                  mem_rd_en;
  logic [WORD_BITS-1:0]  mem_rd_data;
  logic                  mem_wr_en;
  logic [WORD_BITS-1:0]  mem_wr_data;

  entry_t                rd_e;
  entry_t                upd_e;
  logic                  upd_we;
  logic                  rd_v;
  logic                  last;
  logic [CMP_BITS-1:0]   cap_ext;
  logic [CMP_BITS-1:0]   cap_eff;
  logic [CMP_BITS-1:0]   occ_ext;
  logic                  need_evict;
  logic [IDX_BITS-1:0]   ins_slot;
  logic                  ins_evict;
  logic [CAPACITY-1:0]   vic_mask;
  logic [CAPACITY-1:0]   ins_mask;

  lfu_mem #(
    .DEPTH     (CAPACITY),
    .ADDR_BITS (IDX_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (cnt[IDX_BITS-1:0]),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (rd_idx),
    .wr_data (mem_wr_data)
  );

  assign req_ready   = (state == IDLE);
  assign res_valid   = (state == DONE);
  assign mem_rd_en   = ((state == SCAN) || (state == UPDATE)) && (cnt < CNT_BITS'(CAPACITY));
  assign rd_e        = entry_t'(mem_rd_data);
  assign rd_v        = valid[rd_idx];
  assign last        = rd_pend && (rd_idx == IDX_BITS'(CAPACITY - 1));
  assign mem_wr_en   = (state == UPDATE) && rd_pend && upd_we;
  assign mem_wr_data = WORD_BITS'(upd_e);

  always_comb begin
    cap_ext = CMP_BITS'(cap);
    occ_ext = CMP_BITS'(occupancy);
    if (cap_ext == '0) begin
      cap_eff = CMP_BITS'(1);
    end else if (cap_ext > CMP_BITS'(CAPACITY)) begin
      cap_eff = CMP_BITS'(CAPACITY);
    end else begin
      cap_eff = cap_ext;
    end
    need_evict = (occ_ext >= cap_eff) && (occupancy != '0);
    if (need_evict) begin
      ins_slot = (free_found && (free_idx < vic_idx)) ? free_idx : vic_idx;
    end else begin
      ins_slot = free_idx;
    end
    ins_evict = !match_found && (op_r == OP_SET) && need_evict;
    vic_mask  = CAPACITY'(1) << vic_idx;
    ins_mask  = CAPACITY'(1) << ins_slot;
  end

  always_comb begin
    upd_e  = rd_e;
    upd_we = 1'b0;
    if (upd_ins) begin
      if (rd_idx == slot_idx) begin
        upd_e.key   = key_r;
        upd_e.value = wval_r;
        upd_e.count = COUNT_BITS'(1);
        upd_e.rank  = '0;
        upd_we      = 1'b1;
      end else if (rd_v) begin
        upd_we = 1'b1;
        if (!(evict_r && (rd_e.rank > vic_rank))) begin
          upd_e.rank = rd_e.rank + 1'b1;
        end
      end
    end else begin
      if (rd_idx == match_idx) begin
        upd_e.rank = '0;
        if (rd_e.count != '1) begin
          upd_e.count = rd_e.count + 1'b1;
        end
        if (op_r == OP_SET) begin
          upd_e.value = wval_r;
        end
        upd_we = 1'b1;
      end else if (rd_v && (rd_e.rank < m_rank)) begin
        upd_e.rank = rd_e.rank + 1'b1;
        upd_we     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      valid     <= '0;
      occupancy <= '0;
      cnt       <= '0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= mem_rd_en;
      if (mem_rd_en) begin
        rd_idx <= cnt[IDX_BITS-1:0];
        cnt    <= cnt + 1'b1;
      end
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            op_r        <= req.opcode;
            key_r       <= req.key;
            wval_r      <= req.write_value;
            match_found <= 1'b0;
            vic_found   <= 1'b0;
            free_found  <= 1'b0;
            cnt         <= '0;
            state       <= SCAN;
          end
        end
        SCAN: begin
          if (rd_pend) begin
            if (rd_v && (rd_e.key == key_r) && !match_found) begin
              match_found <= 1'b1;
              match_idx   <= rd_idx;
              m_rank      <= rd_e.rank;
              m_value     <= rd_e.value;
            end
            if (rd_v && (!vic_found || (rd_e.count < vic_count) ||
                ((rd_e.count == vic_count) && (rd_e.rank > vic_rank)))) begin
              vic_found <= 1'b1;
              vic_idx   <= rd_idx;
              vic_count <= rd_e.count;
              vic_rank  <= rd_e.rank;
              vic_key   <= rd_e.key;
            end
            if (!rd_v && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (last) begin
              state <= DECIDE;
            end
          end
        end
        DECIDE: begin
          cnt             <= '0;
          res.hit         <= match_found;
          res.read_value  <= (match_found && (op_r == OP_GET)) ? m_value : '0;
          res.evicted     <= ins_evict;
          res.evicted_key <= ins_evict ? vic_key : '0;
          if (match_found) begin
            upd_ins <= 1'b0;
            state   <= UPDATE;
          end else if (op_r == OP_GET) begin
            state <= DONE;
          end else begin
            upd_ins  <= 1'b1;
            evict_r  <= need_evict;
            slot_idx <= ins_slot;
            if (need_evict) begin
              valid <= (valid & ~vic_mask) | ins_mask;
            end else begin
              valid     <= valid | ins_mask;
              occupancy <= occupancy + 1'b1;
            end
            state <= UPDATE;
          end
        end
        UPDATE: begin
          if (last) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (res_take) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_BITS'(CAPACITY))
    else $error("Occupancy exceeds the number of entries.");

  a_occ_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == occupancy)
    else $error("Occupancy disagrees with the valid bits.");

  a_hit_keeps_set: assert property (@(posedge clk) disable iff (rst)
    (state == DECIDE) && match_found |=> $stable(occupancy) && $stable(valid))
    else $error("A hit changed the set of held entries.");

  a_evict_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == DONE) && res.evicted |-> (occ_ext >= cap_eff) && !res.hit)
    else $error("An eviction was reported while the cache had room.");
`endif

endmodule

@@ rtl/lfu_cache_with_lru_tiebreak.sv @@
`timescale 1ns / 1ps

// Key-value cache with least-frequently-used replacement and least-recently-used tie break.
// Items enter on the req channel (opcode, key, write_value) and one result item per request
// leaves on the rsp channel (hit, read_value, evicted, evicted_key); both use valid/ready.
// The cfg port writes the number of entries in use; write it only while the block is idle.
// Each request first scans all CAPACITY entries of the entry memory, one read per cycle,
// then, except for a get that misses, sweeps them again to write back counts and ranks.
// The result waits in the engine's DONE state until it moves into the output register, and
// the next request is accepted only after that move, so the block takes a new item only
// once it has finished the last one; a get that misses skips the second sweep.
// The sweeps over the entry memory, one entry at a time, set how often requests are taken.
// Reset empties the cache and sets the capacity register to 16; no memory clearing pass
// is needed since entries are tracked by valid bits.
// A stalled receiver holds the result in the output register; the next request may still be
// accepted and processed, and it waits in its final state until the output register is free.
module lfu_cache_with_lru_tiebreak #(
  parameter int CAPACITY   = lfu_pkg::CAPACITY_DEFAULT,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [lfu_pkg::CFG_BITS-1:0] cfg_wr_data,
  lfu_req_if.sink                      req,
  lfu_rsp_if.source                    rsp
);
  import lfu_pkg::*;

  logic [CFG_BITS-1:0] cap;
  logic                out_valid;
  res_t                out_res;
  req_t                eng_req;
  logic                eng_res_valid;
  res_t                eng_res;
  logic                take;

  assign eng_req.opcode      = req.opcode;
  assign eng_req.key         = req.key;
  assign eng_req.write_value = req.write_value;

  assign take            = !out_valid || rsp.ready;
  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_res.hit;
  assign rsp.read_value  = out_res.read_value;
  assign rsp.evicted     = out_res.evicted;
  assign rsp.evicted_key = out_res.evicted_key;

  lfu_engine #(
    .CAPACITY   (CAPACITY),
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cap       (cap),
    .req_valid (req.valid),
    .req       (eng_req),
    .req_ready (req.ready),
    .res_valid (eng_res_valid),
    .res       (eng_res),
    .res_take  (take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CAPACITY_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
      if (take) begin
        out_valid <= eng_res_valid;
        if (eng_res_valid) begin
          out_res <= eng_res;
        end
      end
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import lfu_pkg::*;

  localparam int SLOTS = CAPACITY_DEFAULT;
  localparam int COUNT_W = 4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int ITEM_LATENCY = 2 * SLOTS + 5;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 400;
  localparam int HOLD_AFTER = 300;
  localparam int PRINT_LIMIT = 40;
  localparam res_t NO_RESULT = '0;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_CAPACITY} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CFG_BITS-1:0] capacity;
    req_t                item;
    res_t                given;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en;
  logic [CFG_BITS-1:0] cfg_wr_data;

  lfu_req_if req_ch ();
  lfu_rsp_if rsp_ch ();

  lfu_cache_with_lru_tiebreak #(
    .CAPACITY  (SLOTS),
    .COUNT_BITS(COUNT_W)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic                  slot_valid [SLOTS] = '{default: 1'b0};
  logic [KEY_BITS-1:0]   slot_key   [SLOTS];
  logic [VALUE_BITS-1:0] slot_value [SLOTS];
  logic [COUNT_W-1:0]    slot_uses  [SLOTS];
  logic [3:0]            slot_age   [SLOTS];
  logic [4:0]            slots_filled = '0;
  logic [CFG_BITS-1:0]   capacity_reg = CAPACITY_RESET;

  res_t pending_results [$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   hits_seen = 0;
  int   evictions_seen = 0;
  int   requests_sent = 0;
  int   capacity_writes = 0;
  int   burst_left = 0;
  int   cycle_count = 0;
  bit   long_hold_done = 1'b0;

  function automatic void promote_entry(input int e);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i] && i != e && slot_age[i] < slot_age[e]) begin
        slot_age[i]++;
      end
    end
    slot_age[e] = '0;
    if (slot_uses[e] != COUNT_MAX) begin
      slot_uses[e]++;
    end
  endfunction

  function automatic res_t apply_request(input req_t r);
    res_t       out;
    int         found;
    int         victim;
    int         slot;
    logic [4:0] limit;
    logic [3:0] gone_age;
    out = NO_RESULT;
    found = -1;
    victim = -1;
    slot = -1;
    if (capacity_reg == 0) begin
      limit = 5'd1;
    end else if (capacity_reg > SLOTS) begin
      limit = 5'(SLOTS);
    end else begin
      limit = capacity_reg;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (found < 0 && slot_valid[i] && slot_key[i] == r.key) begin
        found = i;
      end
    end
    if (found >= 0) begin
      out.hit = 1'b1;
      if (r.opcode == OP_GET) begin
        out.read_value = slot_value[found];
      end else begin
        slot_value[found] = r.write_value;
      end
      promote_entry(found);
      return out;
    end
    if (r.opcode == OP_GET) begin
      return out;
    end
    if (slots_filled >= limit && slots_filled > 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
            (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim]))) begin
          victim = i;
        end
      end
      out.evicted = 1'b1;
      out.evicted_key = slot_key[victim];
      gone_age = slot_age[victim];
      slot_valid[victim] = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i] && slot_age[i] > gone_age) begin
          slot_age[i]--;
        end
      end
      slots_filled--;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (slot < 0 && !slot_valid[i]) begin
        slot = i;
      end
    end
    if (slot >= 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_valid[i]) begin
          slot_age[i]++;
        end
      end
      slot_valid[slot] = 1'b1;
      slot_key[slot] = r.key;
      slot_value[slot] = r.write_value;
      slot_uses[slot] = COUNT_W'(1);
      slot_age[slot] = '0;
      slots_filled++;
    end
    return out;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("[%0t] mismatch in %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  task automatic send_item(input req_t r, input bit typed, input res_t given);
    int   gap;
    res_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.opcode <= r.opcode;
    req_ch.key <= r.key;
    req_ch.write_value <= r.write_value;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_request(r);
    pending_results.push_back(typed ? given : predicted);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_BITS-1:0] value);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    capacity_reg = value;
    capacity_writes++;
    burst_left = 0;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {16'h0, rsp_ch.evicted_key}, 32'h0);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (rsp_ch.hit) hits_seen++;
        if (rsp_ch.evicted) evictions_seen++;
        if (rsp_ch.hit !== want.hit) begin
          report_mismatch("hit", 32'(rsp_ch.hit), 32'(want.hit));
        end
        if (rsp_ch.read_value !== want.read_value) begin
          report_mismatch("read_value", rsp_ch.read_value, want.read_value);
        end
        if (rsp_ch.evicted !== want.evicted) begin
          report_mismatch("evicted", 32'(rsp_ch.evicted), 32'(want.evicted));
        end
        if (rsp_ch.evicted_key !== want.evicted_key) begin
          report_mismatch("evicted_key", 32'(rsp_ch.evicted_key), 32'(want.evicted_key));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver holds off once for a long stretch so that the cache fills up and
  // stalls its input; otherwise it switches between stall patterns of random length.
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_done = 1'b1;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
        2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready <= ((left % 24) >= 8);
      endcase
      @(negedge clk);
    end
  end

  initial begin
    stim_row_t           directed_rows [25];
    logic [CFG_BITS-1:0] fixed_caps [8];
    logic [KEY_BITS-1:0] key_pool [$];
    logic [CFG_BITS-1:0] cap;
    int                  pool_size;
    int                  pick;
    int                  directed_items;
    req_t                r;

    req_ch.valid = 1'b0;
    req_ch.opcode = OP_GET;
    req_ch.key = '0;
    req_ch.write_value = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    directed_items = 0;

    directed_rows = '{
      '{ROW_TYPED,    5'd0,  '{OP_GET, 16'h0000, 32'h0000_0000}, NO_RESULT},
      '{ROW_TYPED,    5'd0,  '{OP_GET, 16'hFFFF, 32'hFFFF_FFFF}, NO_RESULT},
      '{ROW_TYPED,    5'd0,  '{OP_SET, 16'h0000, 32'h0000_0000}, NO_RESULT},
      '{ROW_TYPED,    5'd0,  '{OP_SET, 16'hFFFF, 32'hFFFF_FFFF}, NO_RESULT},
      '{ROW_TYPED,    5'd0,  '{OP_GET, 16'hFFFF, 32'h0000_0000},
        '{1'b1, 32'hFFFF_FFFF, 1'b0, 16'h0000}},
      '{ROW_TYPED,    5'd0,  '{OP_GET, 16'h0000, 32'h1234_5678},
        '{1'b1, 32'h0000_0000, 1'b0, 16'h0000}},
      '{ROW_TYPED,    5'd0,  '{OP_SET, 16'h0000, 32'hA5A5_5A5A},
        '{1'b1, 32'h0000_0000, 1'b0, 16'h0000}},
      '{ROW_CAPACITY, 5'd0,  '{OP_GET, 16'h0000, 32'h0000_0000}, NO_RESULT},
      '{ROW_PREDICT,  5'd0,  '{OP_SET, 16'h1234, 32'h0000_0001}, NO_RESULT},
      '{ROW_TYPED,    5'd0,  '{OP_GET, 16'hFFFF, 32'h0000_0000}, NO_RESULT},
      '{ROW_PREDICT,  5'd0,  '{OP_GET, 16'h0000, 32'h0000_0000}, NO_RESULT},
      '{ROW_CAPACITY, 5'd1,  '{OP_GET, 16'h0000, 32'h0000_0000}, NO_RESULT},
      '{ROW_PREDICT,  5'd0,  '{OP_SET, 16'h8001, 32'h8000_0001}, NO_RESULT},
      '{ROW_CAPACITY, 5'd3,  '{OP_GET, 16'h0000, 32'h0000_0000}, NO_RESULT},
      '{ROW_PREDICT,  5'd0,  '{OP_SET, 16'h0101, 32'h0101_0101}, NO_RESULT},
      '{ROW_PREDICT,  5'd0,  '{OP_SET, 16'h0202, 32'h0202_0202}, NO_RESULT},
      '{ROW_PREDICT,  5'd0,  '{OP_SET, 16'h0303, 32'h0303_0303}, NO_RESULT},
      '{ROW_PREDICT,  5'd0,  '{OP_GET, 16'h0202, 32'h0000_0000}, NO_RESULT},
      '{ROW_PREDICT,  5'd0,  '{OP_SET, 16'h0404, 32'h0404_0404}, NO_RESULT},
      '{ROW_CAPACITY, 5'd31, '{OP_GET, 16'h0000, 32'h0000_0000}, NO_RESULT},
      '{ROW_PREDICT,  5'd0,  '{OP_SET, 16'h7FFF, 32'h7FFF_FFFF}, NO_RESULT},
      '{ROW_PREDICT,  5'd0,  '{OP_SET, 16'h8000, 32'h8000_0000}, NO_RESULT},
      '{ROW_CAPACITY, 5'd16, '{OP_GET, 16'h0000, 32'h0000_0000}, NO_RESULT},
      '{ROW_PREDICT,  5'd0,  '{OP_GET, 16'h7FFF, 32'h0000_0000}, NO_RESULT},
      '{ROW_PREDICT,  5'd0,  '{OP_SET, 16'h0000, 32'h0000_0000}, NO_RESULT}
    };
    fixed_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd5, 5'd17, 5'd8};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[n]) begin
      case (directed_rows[n].kind)
        ROW_CAPACITY: write_capacity(directed_rows[n].capacity);
        ROW_TYPED: begin
          send_item(directed_rows[n].item, 1'b1, directed_rows[n].given);
          directed_items++;
        end
        default: begin
          send_item(directed_rows[n].item, 1'b0, NO_RESULT);
          directed_items++;
        end
      endcase
    end

    // Each phase works a small pool of keys so that hits, updates, evictions and
    // saturated counts are frequent; a hot key is read over and over.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      cap = (p < 8) ? fixed_caps[p] : 5'($urandom_range(0, 31));
      write_capacity(cap);
      pool_size = ((cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : int'(cap)) + $urandom_range(1, 6);
      key_pool.delete();
      for (int k = 0; k < pool_size; k++) begin
        case ($urandom_range(0, 7))
          0: key_pool.push_back(16'h0000);
          1: key_pool.push_back(16'hFFFF);
          default: key_pool.push_back(16'($urandom_range(0, 16'hFFFF)));
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          r.key = 16'($urandom_range(0, 16'hFFFF));
        end else if (pick == 1) begin
          r.key = key_pool[0];
        end else begin
          r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        if (pick == 1) begin
          r.opcode = OP_GET;
        end else begin
          r.opcode = ($urandom_range(0, 1) == 1) ? OP_SET : OP_GET;
        end
        r.write_value = $urandom();
        send_item(r, 1'b0, NO_RESULT);
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (ITEM_LATENCY) @(negedge clk);

    $display("tb: %0d requests (%0d directed) over %0d capacity settings, %0d results checked",
             requests_sent, directed_items, capacity_writes, results_seen);
    $display("tb: %0d hits, %0d evictions, long output stall %s, %0d mismatches",
             hits_seen, evictions_seen, long_hold_done ? "done" : "not reached", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
